// File: rtl/assert_macros.svh
// Assertion macros used by the checker file csa_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication that must hold whenever the antecedent is true.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// File: rtl/csa_pkg.sv
package csa_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 30;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int OFF_CFG_W = 4;
    localparam int SETB_CFG_W = 3;
    localparam int WAYS_CFG_W = 3;
    localparam int WAY_OUT_W = 2;
    localparam int SET_OUT_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam int M_TDATA_W = 208;

    localparam logic [OFF_CFG_W-1:0]  OFF_MIN  = 4'd2;
    localparam logic [OFF_CFG_W-1:0]  OFF_MAX  = 4'd12;
    localparam logic [SETB_CFG_W-1:0] SETB_MAX = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LRU    = 3'd4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic lookup_read;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/csa_ctrl.sv
module csa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  csa_pkg::status_t  status,
    output csa_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.lookup_read = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // Wait here while the previous word still sits unread.
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/csa_dp.sv
module csa_dp #(
    parameter int MAX_SETS = 64,
    parameter int WAYS     = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  csa_pkg::cmd_t                         cmd,
    output csa_pkg::status_t                      status,
    input  logic                                  cfg_valid,
    input  logic [csa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [csa_pkg::ADDR_W-1:0]            s_tdata,
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [csa_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W   = $clog2(WAYS + 1);
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;

    typedef struct packed {
        logic [WAYS-1:0]                           valid;
        logic [WAYS-1:0][csa_pkg::TAG_W-1:0]       tag;
        logic [WAYS-1:0][csa_pkg::STAMP_W-1:0]     fill;
        logic [WAYS-1:0][csa_pkg::STAMP_W-1:0]     used;
    } row_t;

    row_t mem [MAX_SETS];

    logic [csa_pkg::OFF_CFG_W-1:0]  off_reg;
    logic [csa_pkg::SETB_CFG_W-1:0] setb_reg;
    logic [csa_pkg::WAYS_CFG_W-1:0] ways_reg;
    logic                           wa_reg;
    logic                           lru_reg;

    logic [SET_W-1:0]               clr_cnt_reg;
    logic [SET_W-1:0]               set_reg;
    logic [csa_pkg::TAG_W-1:0]      tag_reg;
    logic                           store_reg;
    row_t                           row_reg;
    logic [csa_pkg::STAMP_W-1:0]    seq_reg;

    logic [csa_pkg::CNT_W-1:0] loads_reg, stores_reg, lh_reg, lm_reg, sh_reg, sm_reg;
    logic                      m_valid_reg;
    logic [csa_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Address split with the register values clamped to their legal ranges.
    logic [csa_pkg::OFF_CFG_W-1:0]  ob;
    logic [csa_pkg::SETB_CFG_W-1:0] sb;
    logic [NW_W-1:0]                nw;
    logic [csa_pkg::ADDR_W-1:0]     set_full, tag_full, set_mask;
    logic [SET_W-1:0]               set_next;

    always_comb begin
        if (off_reg < csa_pkg::OFF_MIN) begin
            ob = csa_pkg::OFF_MIN;
        end else if (off_reg > csa_pkg::OFF_MAX) begin
            ob = csa_pkg::OFF_MAX;
        end else begin
            ob = off_reg;
        end
        sb = (setb_reg > csa_pkg::SETB_MAX) ? csa_pkg::SETB_MAX : setb_reg;
        if (32'(sb) > 32'(SB_MAX)) begin
            sb = csa_pkg::SETB_CFG_W'(SB_MAX);
        end
        if (ways_reg == '0) begin
            nw = NW_W'(1);
        end else if (32'(ways_reg) > 32'(WAYS)) begin
            nw = NW_W'(WAYS);
        end else begin
            nw = NW_W'(ways_reg);
        end
        set_mask = (32'd1 << sb) - 32'd1;
        set_full = (s_tdata >> ob) & set_mask;
        tag_full = s_tdata >> (5'(ob) + 5'(sb));
        set_next = set_full[SET_W-1:0];
    end

    // Lookup, victim choice and row update for the access held in the registers.
    logic                  hit, alloc, found_inv, evict;
    logic [WAY_W-1:0]      hit_way, inv_way, vic_way, way_sel;
    logic [csa_pkg::STAMP_W-1:0] best, stamp;
    row_t                  row_new;
    logic [31:0]           way32, set32;

    always_comb begin
        hit = 1'b0;
        hit_way = '0;
        found_inv = 1'b0;
        inv_way = '0;
        vic_way = '0;
        best = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (NW_W'(w) < nw && row_reg.valid[w] && row_reg.tag[w] == tag_reg) begin
                hit = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (NW_W'(w) < nw && !row_reg.valid[w]) begin
                found_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            stamp = lru_reg ? row_reg.used[w] : row_reg.fill[w];
            if (NW_W'(w) < nw && (w == 0 || stamp < best)) begin
                best = stamp;
                vic_way = WAY_W'(w);
            end
        end
        alloc = !hit && (store_reg == csa_pkg::CMD_LOAD || wa_reg);
        evict = alloc && !found_inv;
        if (hit) begin
            way_sel = hit_way;
        end else if (!alloc) begin
            way_sel = '0;
        end else if (found_inv) begin
            way_sel = inv_way;
        end else begin
            way_sel = vic_way;
        end
        row_new = row_reg;
        if (hit) begin
            row_new.used[way_sel] = seq_reg;
        end else if (alloc) begin
            row_new.valid[way_sel] = 1'b1;
            row_new.tag[way_sel]   = tag_reg;
            row_new.fill[way_sel]  = seq_reg;
            row_new.used[way_sel]  = seq_reg;
        end
        way32 = 32'(way_sel);
        set32 = 32'(set_reg);
    end

    // Counter values after this access.
    logic [csa_pkg::CNT_W-1:0] loads_n, stores_n, lh_n, lm_n, sh_n, sm_n;

    function automatic logic [csa_pkg::CNT_W-1:0] sat_inc(
        input logic [csa_pkg::CNT_W-1:0] c,
        input logic                      en
    );
        sat_inc = (en && c != '1) ? c + 1'b1 : c;
    endfunction

    always_comb begin
        loads_n  = sat_inc(loads_reg,  store_reg == csa_pkg::CMD_LOAD);
        stores_n = sat_inc(stores_reg, store_reg == csa_pkg::CMD_STORE);
        lh_n = sat_inc(lh_reg, store_reg == csa_pkg::CMD_LOAD && hit);
        lm_n = sat_inc(lm_reg, store_reg == csa_pkg::CMD_LOAD && !hit);
        sh_n = sat_inc(sh_reg, store_reg == csa_pkg::CMD_STORE && hit);
        sm_n = sat_inc(sm_reg, store_reg == csa_pkg::CMD_STORE && !hit);
        m_data_next = {5'd0, sm_n, sh_n, lm_n, lh_n, stores_n, loads_n,
                       set32[csa_pkg::SET_OUT_W-1:0], way32[csa_pkg::WAY_OUT_W-1:0],
                       evict, alloc, hit};
    end

    // Tag store: one registered read port, one write port shared by clear and commit.
    always_ff @(posedge aclk) begin
        if (cmd.lookup_read) begin
            row_reg <= mem[set_next];
        end
        if (cmd.clear_step) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.commit) begin
            mem[set_reg] <= row_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup_read) begin
            set_reg   <= set_next;
            tag_reg   <= tag_full[csa_pkg::TAG_W-1:0];
            store_reg <= s_tuser[0];
        end
        if (cmd.commit) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg     <= 4'd4;
            setb_reg    <= 3'd0;
            ways_reg    <= 3'd4;
            wa_reg      <= 1'b1;
            lru_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            seq_reg     <= '0;
            loads_reg   <= '0;
            stores_reg  <= '0;
            lh_reg      <= '0;
            lm_reg      <= '0;
            sh_reg      <= '0;
            sm_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    csa_pkg::REG_OFFSET_BITS:    off_reg  <= cfg_data;
                    csa_pkg::REG_SET_BITS:       setb_reg <= cfg_data[2:0];
                    csa_pkg::REG_WAYS_IN_USE:    ways_reg <= cfg_data[2:0];
                    csa_pkg::REG_WRITE_ALLOCATE: wa_reg   <= cfg_data[0];
                    csa_pkg::REG_REPLACE_LRU:    lru_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                seq_reg    <= seq_reg + 1'b1;
                loads_reg  <= loads_n;
                stores_reg <= stores_n;
                lh_reg     <= lh_n;
                lm_reg     <= lm_n;
                sh_reg     <= sh_n;
                sm_reg     <= sm_n;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Fields from the top: clear_last, out_free.
    assign status   = {(clr_cnt_reg == SET_W'(MAX_SETS - 1)), (!m_valid_reg || m_tready)};
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/set_assoc_cache_hit_miss_model.sv
// Each access passes through the controller states ST_IDLE and ST_LOOK: the
// set's row is read from the tag store at acceptance, and the updated row is
// written back on leaving ST_LOOK, when the result word is loaded into the
// output register; a result still unread holds it there. A new access is taken only after that write-back.
// After reset the block clears the valid bits one set per cycle, all MAX_SETS sets, before it takes an access.
module set_assoc_cache_hit_miss_model #(
    parameter int MAX_SETS = 64,
    parameter int WAYS     = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [csa_pkg::ADDR_W-1:0]        s_tdata,   // address
    input  logic [0:0]                        s_tuser,   // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit, filled, evicted, way_used[1:0], set_used[5:0], loads_seen, stores_seen,
    // load_hits, load_misses, store_hits, store_misses, zero fill
    output logic [csa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    csa_pkg::cmd_t    cmd;
    csa_pkg::status_t status;

    assign cfg_ready = 1'b1;

    csa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csa_dp #(
        .MAX_SETS (MAX_SETS),
        .WAYS     (WAYS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/csa_checker.sv
`include "assert_macros.svh"

module csa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [csa_pkg::M_TDATA_W-1:0] m_tdata
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result word changed while stalled")
    `ASSERT_IMPL(a_hit_no_fill, aclk, aresetn, m_tvalid, !(m_tdata[0] && m_tdata[1]), "hit and fill together")
    `ASSERT_IMPL(a_evict_fill, aclk, aresetn, m_tvalid, (!m_tdata[2] || m_tdata[1]), "eviction without fill")
    `ASSERT_CLK(a_one_at_a_time, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input taken while an access is in flight")

endmodule

bind set_assoc_cache_hit_miss_model csa_checker u_csa_checker (.*);
